// ===== src/dpsc_pkg.sv =====
// Package: shared constants, types and command/status structs for the prime sum counter.
package dpsc_pkg;
    localparam int MAX_SUM_DEF    = 1023;
    localparam int MAX_PRIMES_DEF = 256;
    localparam int MAX_TERMS_DEF  = 15;

    localparam int SUM_W   = 10;
    localparam int TERM_W  = 4;
    localparam int COUNT_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic clear;      // write one table entry at the sweep counter: one at entry 0, zero elsewhere
        logic clr_start;  // reset sweep counter
        logic sieve_start;
        logic sieve_step;
        logic build_start;
        logic build_step;
        logic query;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic sieve_done;
        logic build_done;
    } t_stat;
endpackage

// ===== src/dpsc_datapath.sv =====
// Datapath: prime store, count table memory, sieve and table-build counters, query read.
module dpsc_datapath #(
    parameter int MAX_SUM    = dpsc_pkg::MAX_SUM_DEF,
    parameter int MAX_PRIMES = dpsc_pkg::MAX_PRIMES_DEF,
    parameter int MAX_TERMS  = dpsc_pkg::MAX_TERMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dpsc_pkg::t_cmd                i_cmd,
    output dpsc_pkg::t_stat               o_stat,
    input  logic [dpsc_pkg::SUM_W-1:0]    i_target_sum,
    input  logic [dpsc_pkg::TERM_W-1:0]   i_term_count,
    output logic [dpsc_pkg::COUNT_W-1:0]  o_way_count,
    output logic [dpsc_pkg::STAT_W-1:0]   o_status
);
    import dpsc_pkg::*;

    localparam int SPAN   = MAX_SUM + 1;
    localparam int DEPTH  = (MAX_TERMS + 1) * SPAN;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = $clog2(SPAN);
    localparam int TW     = $clog2(MAX_TERMS + 1);
    localparam int PAW    = $clog2(MAX_PRIMES);
    localparam int PTW    = $clog2(MAX_PRIMES + 1);
    localparam int MW     = 2 * SW + 2;

    // Memories
    logic [SW-1:0]      r_primes [MAX_PRIMES];
    logic [COUNT_W-1:0] r_table  [DEPTH];

    // Sweep / sieve / build state
    logic [AW:0]   r_clr;
    logic [SW:0]   r_cand;
    logic [PTW-1:0] r_ptotal;
    logic [PTW-1:0] r_j;
    logic [SW-1:0] r_rem;    // cand mod d computed by repeated subtraction
    logic [2:0]    r_sph;    // sieve phase
    logic [SW-1:0] r_d;
    logic          r_isp;

    logic [PTW-1:0] r_pi;
    logic [SW-1:0]  r_p;
    logic [TW-1:0]  r_t;
    logic [SW-1:0]  r_s;
    logic [1:0]     r_bph;
    logic [COUNT_W-1:0] r_rd_src;
    logic [COUNT_W-1:0] r_rd_dst;
    logic [AW-1:0]  r_dst_a;

    logic          r_qok;
    logic          r_qzero;

    logic [MW-1:0] sq;
    logic [COUNT_W:0] sum;
    logic [AW-1:0] a_dst, a_src, a_q, a_rd;
    logic          sieve_end;
    logic          build_end;

    assign sq = MW'(r_d) * MW'(r_d);
    assign sum = {1'b0, r_rd_src} + {1'b0, r_rd_dst};
    assign a_dst = AW'(r_t * SPAN) + AW'(r_s);
    assign a_src = AW'((r_t - 1'b1) * SPAN) + AW'(r_s - r_p);
    assign a_q   = AW'(i_term_count * SPAN) + AW'(i_target_sum);
    assign a_rd  = i_cmd.query ? a_q : a_dst;
    assign sieve_end = (r_cand > (SW+1)'(MAX_SUM)) || (r_ptotal == PTW'(MAX_PRIMES));
    assign build_end = (r_pi == r_ptotal);

    assign o_stat.clr_done   = (r_clr == (AW+1)'(DEPTH));
    assign o_stat.sieve_done = sieve_end && (r_sph == 3'd0);
    assign o_stat.build_done = build_end && (r_bph == 2'd0);

    // Table clear sweep and build both write the table; second read port
    // serves the build and the query, and holds the query word until the next one
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear && !o_stat.clr_done) begin
            r_table[r_clr[AW-1:0]] <= (r_clr == '0) ? COUNT_W'(1) : '0;
        end else if (i_cmd.build_step && r_bph == 2'd3) begin
            r_table[r_dst_a] <= sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        end
        r_rd_src <= r_table[a_src];
        if (i_cmd.query || i_cmd.build_step) begin
            r_rd_dst <= r_table[a_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clear && !o_stat.clr_done) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Trial-division sieve: phases 0 pick, 1 load divisor, 2 test, 3 subtract loop, 4 record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sieve_start) begin
            r_cand   <= (SW+1)'(2);
            r_ptotal <= '0;
            r_sph    <= 3'd0;
            r_j      <= '0;
        end else if (i_cmd.sieve_step) begin
            unique case (r_sph)
                3'd0: begin
                    if (!sieve_end) begin
                        r_j   <= '0;
                        r_isp <= 1'b1;
                        r_sph <= 3'd1;
                    end
                end
                3'd1: begin
                    if (r_j == r_ptotal) begin
                        r_sph <= 3'd4;
                    end else begin
                        r_d   <= r_primes[r_j[PAW-1:0]];
                        r_sph <= 3'd2;
                    end
                end
                3'd2: begin
                    if (sq > MW'(r_cand)) begin
                        r_sph <= 3'd4;
                    end else begin
                        r_rem <= r_cand[SW-1:0];
                        r_sph <= 3'd3;
                    end
                end
                3'd3: begin
                    if (r_rem >= r_d) begin
                        r_rem <= r_rem - r_d;
                    end else if (r_rem == '0) begin
                        r_isp <= 1'b0;
                        r_sph <= 3'd4;
                    end else begin
                        r_j   <= r_j + 1'b1;
                        r_sph <= 3'd1;
                    end
                end
                default: begin
                    if (r_isp) begin
                        r_primes[r_ptotal[PAW-1:0]] <= r_cand[SW-1:0];
                        r_ptotal <= r_ptotal + 1'b1;
                    end
                    r_cand <= r_cand + 1'b1;
                    r_sph  <= 3'd0;
                end
            endcase
        end
    end

    // Build: per prime, t descending, s descending; 0 setup, 1 read, 2 wait, 3 write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.build_start) begin
            r_pi  <= '0;
            r_bph <= 2'd0;
        end else if (i_cmd.build_step) begin
            case (r_bph)
                2'd0: begin
                    if (!build_end) begin
                        r_p   <= r_primes[r_pi[PAW-1:0]];
                        r_t   <= TW'(MAX_TERMS);
                        r_s   <= SW'(MAX_SUM);
                        r_bph <= 2'd1;
                    end
                end
                2'd1: begin
                    if (r_s < r_p) begin
                        if (r_t == TW'(1)) begin
                            r_pi  <= r_pi + 1'b1;
                            r_bph <= 2'd0;
                        end else begin
                            r_t <= r_t - 1'b1;
                            r_s <= SW'(MAX_SUM);
                        end
                    end else begin
                        r_dst_a <= a_dst;
                        r_bph   <= 2'd2;
                    end
                end
                2'd2: r_bph <= 2'd3;
                default: begin
                    // s >= p >= 2 here, so the step down cannot wrap
                    r_s   <= r_s - 1'b1;
                    r_bph <= 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_qzero <= (i_term_count == '0);
            r_qok   <= (32'(i_target_sum) <= 32'(MAX_SUM))
                    && (32'(i_term_count) <= 32'(MAX_TERMS));
        end
    end

    always_comb begin
        o_way_count = '0;
        o_status    = ST_OK;
        if (r_qzero) begin
            o_status = ST_ZERO;
        end else if (r_qok) begin
            o_way_count = r_rd_dst;
            if (r_rd_dst == '1) o_status = ST_SAT;
        end
    end
endmodule

// ===== src/dpsc_ctrl.sv =====
// Controller: one-shot table build sequencing and query handshake.
module dpsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output dpsc_pkg::t_cmd   o_cmd,
    input  dpsc_pkg::t_stat  i_stat
);
    import dpsc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLR   = 6'b000010,
        S_SIEVE = 6'b000100,
        S_BUILD = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_ready_tbl, n_ready_tbl;

    assign o_ready = (r_state == S_IDLE) && r_ready_tbl;
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state     = r_state;
        n_ready_tbl = r_ready_tbl;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!r_ready_tbl) begin
                    if (i_valid) begin
                        o_cmd.clr_start = 1'b1;
                        n_state = S_CLR;
                    end
                end else if (i_valid) begin
                    o_cmd.query = 1'b1;
                    n_state = S_READ;
                end
            end
            S_CLR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_done) begin
                    o_cmd.sieve_start = 1'b1;
                    n_state = S_SIEVE;
                end
            end
            S_SIEVE: begin
                o_cmd.sieve_step = 1'b1;
                if (i_stat.sieve_done) begin
                    o_cmd.sieve_step  = 1'b0;
                    o_cmd.build_start = 1'b1;
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                o_cmd.build_step = 1'b1;
                if (i_stat.build_done) begin
                    n_ready_tbl = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready_tbl <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready_tbl <= n_ready_tbl;
        end
    end
endmodule

// ===== src/distinct_prime_sum_counter.sv =====
// Top level: counts sets of k distinct primes summing to n from a precomputed table.
// An accepted request passes the read state, then the result is valid in the output state.
// One request in flight: a new one is accepted only in idle, after the result is taken.
// First request after reset waits for a table clear sweep over (MAX_TERMS+1)*(MAX_SUM+1)
// entries, a trial-division prime scan, and a table build.
// Reset is synchronous active low and forgets the table, forcing a rebuild.
module distinct_prime_sum_counter #(
    parameter int MAX_SUM    = dpsc_pkg::MAX_SUM_DEF,
    parameter int MAX_PRIMES = dpsc_pkg::MAX_PRIMES_DEF,
    parameter int MAX_TERMS  = dpsc_pkg::MAX_TERMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dpsc_pkg::SUM_W-1:0]    i_target_sum,
    input  logic [dpsc_pkg::TERM_W-1:0]   i_term_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dpsc_pkg::COUNT_W-1:0]  o_way_count,
    output logic [dpsc_pkg::STAT_W-1:0]   o_status
);
    import dpsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dpsc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_cmd(cmd), .i_stat(stat)
    );

    dpsc_datapath #(
        .MAX_SUM(MAX_SUM), .MAX_PRIMES(MAX_PRIMES), .MAX_TERMS(MAX_TERMS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat),
        .i_target_sum(i_target_sum), .i_term_count(i_term_count),
        .o_way_count(o_way_count), .o_status(o_status)
    );
endmodule

// ===== bench/distinct_prime_sum_counter_tb.sv =====
// Testbench for distinct_prime_sum_counter: directed, random queries vs. typed or table-predicted results.
module distinct_prime_sum_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpsc_pkg::*;

    localparam int SPAN  = MAX_SUM_DEF + 1;
    localparam int NRAND = 1080;

    typedef struct {
        logic [COUNT_W-1:0] ways;
        logic [STAT_W-1:0]  stat;
    } t_answer;

    typedef struct {
        logic [SUM_W-1:0]   sum;
        logic [TERM_W-1:0]  terms;
        bit                 typed;
        logic [COUNT_W-1:0] ways;
        logic [STAT_W-1:0]  stat;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [SUM_W-1:0]    i_target_sum;
    logic [TERM_W-1:0]   i_term_count;
    logic                o_valid;
    logic                i_ready;
    logic [COUNT_W-1:0]  o_way_count;
    logic [STAT_W-1:0]   o_status;

    logic [COUNT_W-1:0]  ways_table [0:(MAX_TERMS_DEF+1)*SPAN-1];
    t_answer             pending_answers[$];
    bit                  steady;
    int                  errors;
    int                  answered;
    int                  zero_terms;
    int                  nonzero_ways;

    distinct_prime_sum_counter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_target_sum(i_target_sum), .i_term_count(i_term_count),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_way_count(o_way_count), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(64'd1_500_000_000);
        $display("distinct_prime_sum_counter_tb: done, errors");
        $finish;
    end

    function automatic void build_ways_table();
        int primes[$];
        int p;
        bit is_p;
        logic [COUNT_W:0] acc;
        for (int i = 0; i < (MAX_TERMS_DEF+1)*SPAN; i++) ways_table[i] = '0;
        ways_table[0] = 1;
        for (int c = 2; c <= MAX_SUM_DEF && primes.size() < MAX_PRIMES_DEF; c++) begin
            is_p = 1;
            foreach (primes[j]) begin
                if (primes[j] * primes[j] > c) break;
                if (c % primes[j] == 0) begin
                    is_p = 0;
                    break;
                end
            end
            if (is_p) primes.push_back(c);
        end
        foreach (primes[i]) begin
            p = primes[i];
            for (int t = MAX_TERMS_DEF; t >= 1; t--) begin
                for (int s = MAX_SUM_DEF; s >= p; s--) begin
                    acc = ways_table[t*SPAN+s] + ways_table[(t-1)*SPAN+s-p];
                    ways_table[t*SPAN+s] = acc[COUNT_W] ? '1 : acc[COUNT_W-1:0];
                end
            end
        end
    endfunction

    function automatic t_answer predict_ways(logic [SUM_W-1:0] sum, logic [TERM_W-1:0] terms);
        t_answer a;
        a.ways = '0;
        a.stat = ST_OK;
        if (terms == 0) begin
            a.stat = ST_ZERO;
        end else if (sum <= MAX_SUM_DEF && terms <= MAX_TERMS_DEF) begin
            a.ways = ways_table[terms*SPAN+sum];
            if (a.ways == '1) a.stat = ST_SAT;
        end
        return a;
    endfunction

    task automatic send_query(t_row r);
        t_answer a;
        i_valid      <= 1'b1;
        i_target_sum <= r.sum;
        i_term_count <= r.terms;
        do @(posedge i_clk); while (!o_ready);
        a = predict_ways(r.sum, r.terms);
        if (r.typed) begin
            a.ways = r.ways;
            a.stat = r.stat;
        end
        pending_answers.push_back(a);
        if (r.terms == 0) zero_terms++;
        if (!steady && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result ways=%0d status=%0d",
                             $realtime, o_way_count, o_status);
                    errors++;
                end else begin
                    t_answer e;
                    e = pending_answers.pop_front();
                    answered++;
                    if (o_way_count != 0) nonzero_ways++;
                    if (o_way_count !== e.ways) begin
                        $display("%0t: way_count expected %0d actual %0d",
                                 $realtime, e.ways, o_way_count);
                        errors++;
                    end
                    if (o_status !== e.stat) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, e.stat, o_status);
                        errors++;
                    end
                end
            end
            i_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
        end
    end

    initial begin
        t_row directed[$];
        t_row r;
        int wait_cycles;
        errors = 0;
        answered = 0;
        zero_terms = 0;
        nonzero_ways = 0;
        steady = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_target_sum = '0;
        i_term_count = '0;
        build_ways_table();

        // sum, terms, typed, ways, status
        directed = '{
            '{10'd0,    4'd0,  1, 32'd0, ST_ZERO},
            '{10'd1023, 4'd0,  1, 32'd0, ST_ZERO},
            '{10'd0,    4'd1,  1, 32'd0, ST_OK},
            '{10'd2,    4'd1,  1, 32'd1, ST_OK},
            '{10'd3,    4'd1,  1, 32'd1, ST_OK},
            '{10'd4,    4'd1,  1, 32'd0, ST_OK},
            '{10'd4,    4'd2,  1, 32'd0, ST_OK},
            '{10'd5,    4'd2,  1, 32'd1, ST_OK},
            '{10'd10,   4'd3,  1, 32'd1, ST_OK},
            '{10'd1021, 4'd1,  1, 32'd1, ST_OK},
            '{10'd1023, 4'd1,  1, 32'd0, ST_OK},
            '{10'd1,    4'd15, 1, 32'd0, ST_OK},
            '{10'd1023, 4'd15, 0, 32'd0, ST_OK},
            '{10'd1022, 4'd14, 0, 32'd0, ST_OK},
            '{10'd1000, 4'd8,  0, 32'd0, ST_OK},
            '{10'd100,  4'd2,  0, 32'd0, ST_OK},
            '{10'd512,  4'd7,  0, 32'd0, ST_OK},
            '{10'd341,  4'd10, 0, 32'd0, ST_OK},
            '{10'd682,  4'd5,  0, 32'd0, ST_OK},
            '{10'd328,  4'd15, 0, 32'd0, ST_OK},
            '{10'd1023, 4'd4,  0, 32'd0, ST_OK}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_query(directed[i]);

        for (int n = 0; n < NRAND; n++) begin
            if (n == 200) steady = 1;
            if (n == 400) steady = 0;
            if (n == 600) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_answers.size() != 0);
            end
            r.typed = 0;
            r.sum   = $urandom_range(0, 1023);
            r.terms = ($urandom_range(99) < 5) ? 4'd0 : 4'($urandom_range(1, 15));
            if ($urandom_range(99) < 10) r.sum = ~r.sum;
            send_query(r);
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_answers.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);

        $display("covered %0d queries (%0d with zero terms, %0d nonzero counts), one table build",
                 answered, zero_terms, nonzero_ways);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("distinct_prime_sum_counter_tb: done, clean");
        end else begin
            $display("distinct_prime_sum_counter_tb: done, errors");
        end
        $finish;
    end
endmodule
